FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

FILE: src/tlts_pkg.sv
// Shared types and constants of the two-level thread scheduler.
// Depends on nothing.
`timescale 1ns / 1ps
package tlts_pkg;
    localparam int MaxThreads = 16;
    localparam int SlotW = $clog2(MaxThreads);
    localparam int CntW = $clog2(MaxThreads + 1);

    typedef logic [SlotW-1:0] t_slot;
    typedef logic [CntW-1:0] t_cnt;

    localparam logic [2:0] ACT_TICK = 3'd0;
    localparam logic [2:0] ACT_CREATE = 3'd1;
    localparam logic [2:0] ACT_READ = 3'd2;
    localparam logic [2:0] ACT_DONE = 3'd3;
    localparam logic [2:0] ACT_EXIT = 3'd4;

    localparam logic [3:0] EV_NONE = 4'd0;
    localparam logic [3:0] EV_CREATED = 4'd1;
    localparam logic [3:0] EV_CFAIL = 4'd2;
    localparam logic [3:0] EV_PREEMPT = 4'd3;
    localparam logic [3:0] EV_QSWITCH = 4'd4;
    localparam logic [3:0] EV_EJECT = 4'd5;
    localparam logic [3:0] EV_FINISH = 4'd6;
    localparam logic [3:0] EV_BLOCK = 4'd7;
    localparam logic [3:0] EV_WOKEN = 4'd8;
    localparam logic [3:0] EV_LEAVE = 4'd9;
    localparam logic [3:0] EV_ALLDONE = 4'd10;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN = 2'd2;
    localparam logic [1:0] ST_BLOCK = 2'd3;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_SCAN, OP_DECIDE, OP_INS_START, OP_INS_STEP, OP_PICK
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic ins_done;
        logic need_ins;
        logic need_pick;
    } t_sts;
endpackage

FILE: src/tlts_datapath.sv
// Datapath: slot tables, queues, sorted insert and free-slot walk.
// Depends on tlts_pkg.
`timescale 1ns / 1ps
module tlts_datapath import tlts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_act,
    input  logic        i_hi,
    input  logic [15:0] i_budget,
    input  logic        i_miss,
    input  logic [7:0]  i_quantum,
    output t_sts        o_sts,
    output logic [3:0]  o_ev,
    output logic [3:0]  o_tid,
    output logic [3:0]  o_run_id,
    output logic        o_idle,
    output logic        o_sw
);
    logic [1:0]  r_status [MaxThreads];
    logic        r_high   [MaxThreads];
    logic [7:0]  r_qleft  [MaxThreads];
    logic [16:0] r_bleft  [MaxThreads];
    t_slot r_lowq [MaxThreads];
    t_slot r_hiq  [MaxThreads];
    t_slot r_blkq [MaxThreads];
    t_cnt  r_lown, r_hin, r_blkn;
    t_slot r_cur;
    logic  r_idle;

    logic [2:0]  r_act;
    logic        r_hi, r_miss;
    logic [16:0] r_bud;
    t_slot       r_scan;
    logic        r_found, r_scan_done;
    t_slot       r_ins_slot;
    t_cnt        r_pos;
    logic        r_ins_done, r_need_ins, r_need_pick;
    logic [3:0]  r_ev, r_tid;
    logic        r_sw;

    logic [7:0] w_slice;
    t_slot      w_cur;
    logic [16:0] w_cb;
    assign w_slice = (i_quantum == 8'd0) ? 8'd1 : i_quantum;
    assign w_cur = r_cur;
    assign w_cb = r_bleft[w_cur] - 17'd1;

    assign o_sts = '{scan_done: r_scan_done, ins_done: r_ins_done,
                     need_ins: r_need_ins, need_pick: r_need_pick};
    assign o_ev = r_ev;
    assign o_tid = r_tid;
    assign o_run_id = r_idle ? 4'd0 : 4'(r_cur);
    assign o_idle = r_idle;
    assign o_sw = r_sw;

    logic w_any;
    assign w_any = (r_hin != '0) || (r_lown != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MaxThreads; k++) r_status[k] <= ST_FREE;
            r_lown <= '0; r_hin <= '0; r_blkn <= '0;
            r_cur <= '0; r_idle <= 1'b1;
            r_scan_done <= 1'b0; r_ins_done <= 1'b0;
            r_need_ins <= 1'b0; r_need_pick <= 1'b0;
            r_ev <= EV_NONE; r_tid <= '0; r_sw <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_act <= i_act; r_hi <= i_hi; r_miss <= i_miss;
                    r_bud <= {1'b0, i_budget};
                    r_scan <= '0; r_found <= 1'b0; r_scan_done <= 1'b0;
                    r_need_ins <= 1'b0; r_need_pick <= 1'b0;
                    r_ev <= EV_NONE; r_tid <= '0; r_sw <= 1'b0;
                end
                OP_SCAN: begin
                    // one slot per cycle looking for a free entry
                    if (r_status[r_scan] == ST_FREE) begin
                        r_found <= 1'b1; r_scan_done <= 1'b1;
                    end else if (r_scan == t_slot'(MaxThreads - 1)) begin
                        r_scan_done <= 1'b1;
                    end else begin
                        r_scan <= r_scan + t_slot'(1);
                    end
                end
                OP_DECIDE: begin
                    case (r_act)
                        ACT_TICK: begin
                            if (r_idle) begin
                                if (w_any) begin
                                    r_need_pick <= 1'b1; r_ev <= EV_LEAVE; r_sw <= 1'b1;
                                end
                            end else begin
                                if (!r_high[w_cur] && r_qleft[w_cur] != 8'd0)
                                    r_qleft[w_cur] <= r_qleft[w_cur] - 8'd1;
                                r_bleft[w_cur] <= w_cb;
                                if (w_cb[16]) begin
                                    r_status[w_cur] <= ST_FREE;
                                    r_tid <= 4'(w_cur); r_sw <= 1'b1;
                                    r_ev <= (!w_any && r_blkn == '0) ? EV_ALLDONE : EV_EJECT;
                                    r_need_pick <= 1'b1;
                                end else if (r_hin != '0 && r_high[w_cur]) begin
                                    if ($signed(r_bleft[r_hiq[0]]) < $signed(w_cb)) begin
                                        r_status[w_cur] <= ST_READY;
                                        r_ins_slot <= w_cur; r_need_ins <= 1'b1;
                                        r_need_pick <= 1'b1;
                                        r_ev <= EV_PREEMPT; r_tid <= 4'(w_cur); r_sw <= 1'b1;
                                    end
                                end else if (r_hin != '0) begin
                                    r_status[w_cur] <= ST_READY;
                                    r_qleft[w_cur] <= w_slice;
                                    r_lowq[r_lown[SlotW-1:0]] <= w_cur;
                                    r_lown <= r_lown + t_cnt'(1);
                                    r_need_pick <= 1'b1;
                                    r_ev <= EV_PREEMPT; r_tid <= 4'(w_cur); r_sw <= 1'b1;
                                end else if (!r_high[w_cur] && (r_qleft[w_cur] == 8'd1 ||
                                             r_qleft[w_cur] == 8'd0)) begin
                                    r_qleft[w_cur] <= w_slice;
                                    if (r_lown != '0) begin
                                        r_status[w_cur] <= ST_READY;
                                        r_lowq[r_lown[SlotW-1:0]] <= w_cur;
                                        r_lown <= r_lown + t_cnt'(1);
                                        r_need_pick <= 1'b1;
                                        r_ev <= EV_QSWITCH; r_tid <= 4'(w_cur); r_sw <= 1'b1;
                                    end
                                end
                            end
                        end
                        ACT_CREATE: begin
                            if (!r_found) begin
                                r_ev <= EV_CFAIL;
                            end else begin
                                r_status[r_scan] <= ST_READY;
                                r_high[r_scan] <= r_hi;
                                r_qleft[r_scan] <= w_slice;
                                r_bleft[r_scan] <= r_bud;
                                r_ev <= EV_CREATED; r_tid <= 4'(r_scan);
                                if (!r_hi) begin
                                    r_lowq[r_lown[SlotW-1:0]] <= r_scan;
                                    r_lown <= r_lown + t_cnt'(1);
                                end else if (r_idle) begin
                                    r_ins_slot <= r_scan; r_need_ins <= 1'b1;
                                end else if (!r_high[w_cur]) begin
                                    r_status[w_cur] <= ST_READY;
                                    r_qleft[w_cur] <= w_slice;
                                    r_lowq[r_lown[SlotW-1:0]] <= w_cur;
                                    r_lown <= r_lown + t_cnt'(1);
                                    r_status[r_scan] <= ST_RUN;
                                    r_cur <= r_scan; r_sw <= 1'b1;
                                end else if ($signed(r_bud) < $signed(r_bleft[w_cur])) begin
                                    r_status[w_cur] <= ST_READY;
                                    r_status[r_scan] <= ST_RUN;
                                    r_ins_slot <= w_cur; r_need_ins <= 1'b1;
                                    r_cur <= r_scan; r_sw <= 1'b1;
                                end else begin
                                    r_ins_slot <= r_scan; r_need_ins <= 1'b1;
                                end
                            end
                        end
                        ACT_READ: begin
                            if (!r_idle && r_miss) begin
                                r_status[w_cur] <= ST_BLOCK;
                                if (!r_high[w_cur]) r_qleft[w_cur] <= w_slice;
                                r_blkq[r_blkn[SlotW-1:0]] <= w_cur;
                                r_blkn <= r_blkn + t_cnt'(1);
                                r_need_pick <= 1'b1;
                                r_ev <= EV_BLOCK; r_tid <= 4'(w_cur); r_sw <= 1'b1;
                            end
                        end
                        ACT_DONE: begin
                            if (r_blkn != '0) begin
                                r_status[r_blkq[0]] <= ST_READY;
                                for (int k = 0; k < MaxThreads - 1; k++)
                                    r_blkq[k] <= r_blkq[k+1];
                                r_blkn <= r_blkn - t_cnt'(1);
                                if (r_high[r_blkq[0]]) begin
                                    r_ins_slot <= r_blkq[0]; r_need_ins <= 1'b1;
                                end else begin
                                    r_lowq[r_lown[SlotW-1:0]] <= r_blkq[0];
                                    r_lown <= r_lown + t_cnt'(1);
                                end
                                r_ev <= EV_WOKEN; r_tid <= 4'(r_blkq[0]);
                            end
                        end
                        ACT_EXIT: begin
                            if (!r_idle) begin
                                r_status[w_cur] <= ST_FREE;
                                r_tid <= 4'(w_cur); r_sw <= 1'b1;
                                r_ev <= (!w_any && r_blkn == '0) ? EV_ALLDONE : EV_FINISH;
                                r_need_pick <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_INS_START: begin
                    r_pos <= '0; r_ins_done <= 1'b0;
                end
                OP_INS_STEP: begin
                    // walk the sorted queue; shift the tail right once the place is found
                    // done is registered, so the controller may step again after placing; hold once placed
                    if (!r_ins_done) begin
                        if (r_pos == r_hin || $signed(r_bleft[r_hiq[r_pos[SlotW-1:0]]]) >
                            $signed(r_bleft[r_ins_slot])) begin
                            for (int k = MaxThreads - 1; k > 0; k--)
                                if (t_cnt'(k) > r_pos) r_hiq[k] <= r_hiq[k-1];
                            r_hiq[r_pos[SlotW-1:0]] <= r_ins_slot;
                            r_hin <= r_hin + t_cnt'(1);
                            r_ins_done <= 1'b1;
                        end else begin
                            r_pos <= r_pos + t_cnt'(1);
                        end
                    end
                end
                OP_PICK: begin
                    if (r_hin != '0) begin
                        r_cur <= r_hiq[0]; r_idle <= 1'b0;
                        r_status[r_hiq[0]] <= ST_RUN;
                        for (int k = 0; k < MaxThreads - 1; k++) r_hiq[k] <= r_hiq[k+1];
                        r_hin <= r_hin - t_cnt'(1);
                        if (r_ev == EV_LEAVE) r_tid <= 4'(r_hiq[0]);
                    end else if (r_lown != '0) begin
                        r_cur <= r_lowq[0]; r_idle <= 1'b0;
                        r_status[r_lowq[0]] <= ST_RUN;
                        for (int k = 0; k < MaxThreads - 1; k++) r_lowq[k] <= r_lowq[k+1];
                        r_lown <= r_lown - t_cnt'(1);
                        if (r_ev == EV_LEAVE) r_tid <= 4'(r_lowq[0]);
                    end else begin
                        r_idle <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (i_cmd.op == OP_DECIDE && r_act == ACT_CREATE && r_found && r_hi &&
                !r_idle)
                r_idle <= 1'b0;
        end
    end
endmodule

FILE: src/tlts_ctrl.sv
// Controller state machine sequencing one request through the datapath.
// Depends on tlts_pkg.
`timescale 1ns / 1ps
module tlts_ctrl import tlts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_act,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_INS0, S_INS, S_PICK, S_OUT
    } t_state;
    t_state r_state;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd.op = OP_NOP;
        case (r_state)
            S_IDLE:   if (i_in_valid) o_cmd.op = OP_LOAD;
            S_SCAN:   o_cmd.op = OP_SCAN;
            S_DECIDE: o_cmd.op = OP_DECIDE;
            S_INS0:   o_cmd.op = OP_INS_START;
            S_INS:    o_cmd.op = OP_INS_STEP;
            S_PICK:   o_cmd.op = OP_PICK;
            default:  o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid)
                    r_state <= (i_act == ACT_CREATE) ? S_SCAN : S_DECIDE;
                S_SCAN: if (i_sts.scan_done) r_state <= S_DECIDE;
                S_DECIDE: r_state <= S_INS0;
                S_INS0: begin
                    if (i_sts.need_ins) r_state <= S_INS;
                    else if (i_sts.need_pick) r_state <= S_PICK;
                    else r_state <= S_OUT;
                end
                S_INS: if (i_sts.ins_done)
                    r_state <= i_sts.need_pick ? S_PICK : S_OUT;
                S_PICK: r_state <= S_OUT;
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/two_level_thread_scheduler.sv
// Top level of the two-level thread scheduler.
// Depends on tlts_pkg, tlts_ctrl, tlts_datapath.
//
// One request on s_axis (tdata: action[2:0], priority_high[3], budget_ticks[19:4],
// cache_miss[20]) yields one result on m_axis (tdata: event_res[3:0],
// thread_id[7:4], running_id[11:8], running_idle[12], switched[13]).
// A request passes the free-slot walk (create only), the decide and insert-start
// steps, the sorted insert into the high queue when needed and a pick when a new
// thread is picked, before its result is offered on m_axis.
// One request is in work at a time; the next is taken the cycle after the
// result is taken. The walks step one entry per cycle through the slot table and the high queue.
// The user must write the quantum register on the cfg channel while no request is open;
// the block does not enforce it. Reset: all slots free, queues empty, idle thread
// running, quantum 10. A stalled receiver holds the result; no new request is taken.
`timescale 1ns / 1ps
module two_level_thread_scheduler import tlts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // action, priority_high, budget_ticks, cache_miss
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // event_res, thread_id, running_id, idle, switched
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    logic [7:0] r_quantum;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [3:0] w_ev, w_tid, w_run;
    logic w_idle, w_sw;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_quantum <= 8'd10;
        else if (i_cfg_valid) r_quantum <= i_cfg_data;
    end

    tlts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_act(s_axis_tdata[2:0]), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    tlts_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_act(s_axis_tdata[2:0]), .i_hi(s_axis_tdata[3]),
        .i_budget(s_axis_tdata[19:4]), .i_miss(s_axis_tdata[20]),
        .i_quantum(r_quantum), .o_sts(w_sts),
        .o_ev(w_ev), .o_tid(w_tid), .o_run_id(w_run), .o_idle(w_idle), .o_sw(w_sw)
    );

    assign m_axis_tdata = {2'b00, w_sw, w_idle, w_run, w_tid, w_ev};
endmodule

FILE: src/tlts_checker.sv
// Port-level checker for the thread scheduler, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    `CHK_IMPL(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `CHK_NEXT(a_req_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CHK_IMPL(a_idle_id, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[12],
              m_axis_tdata[11:8] == 4'd0)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind two_level_thread_scheduler tlts_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

FILE: test/two_level_thread_scheduler_test.sv
// Self-checking test of the two-level thread scheduler: drives scheduler events on s_axis,
// predicts each result with an in-bench scheduler model and compares on m_axis.
// Depends on tlts_pkg and two_level_thread_scheduler.
`timescale 1ns / 1ps
module two_level_thread_scheduler_test;
    import tlts_pkg::*;

    localparam int NSlots = 16;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic       cache_miss;
        logic [15:0] budget;
        logic       prio_high;
        logic [2:0] action;
    } t_req;

    typedef struct packed {
        logic       switched;
        logic       idle;
        logic [3:0] running_id;
        logic [3:0] thread_id;
        logic [3:0] event_res;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    two_level_thread_scheduler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // scheduler model state
    logic [7:0]  quantum;
    logic [1:0]  status [NSlots];
    logic        is_high [NSlots];
    logic [7:0]  slice_left [NSlots];
    int          budget_left [NSlots];
    int          low_q[$];
    int          high_q[$];
    int          blk_q[$];
    int          cur;
    bit          idle;

    t_res        sched_expected[$];
    int          errors;
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    function automatic logic [7:0] slice_len();
        return (quantum == 0) ? 8'd1 : quantum;
    endfunction

    function automatic void sorted_insert(int s);
        int pos;
        pos = 0;
        while (pos < high_q.size() && budget_left[high_q[pos]] <= budget_left[s]) pos++;
        high_q.insert(pos, s);
    endfunction

    function automatic void run_slot(int s);
        cur = s;
        idle = 0;
        status[s] = ST_RUN;
    endfunction

    function automatic void pick_next();
        if (high_q.size() > 0) run_slot(high_q.pop_front());
        else if (low_q.size() > 0) run_slot(low_q.pop_front());
        else idle = 1;
    endfunction

    function automatic void requeue_low(int s);
        status[s] = ST_READY;
        slice_left[s] = slice_len();
        low_q.push_back(s);
    endfunction

    function automatic bit none_left();
        return high_q.size() == 0 && low_q.size() == 0 && blk_q.size() == 0;
    endfunction

    function automatic t_res schedule(t_req r);
        t_res o;
        int s;
        logic [3:0] ev;
        int tid;
        bit sw;
        ev = EV_NONE;
        tid = 0;
        sw = 0;
        case (r.action)
            ACT_TICK: begin
                if (idle) begin
                    if (high_q.size() > 0 || low_q.size() > 0) begin
                        pick_next();
                        ev = EV_LEAVE; tid = cur; sw = 1;
                    end
                end else begin
                    if (!is_high[cur] && slice_left[cur] > 0) slice_left[cur]--;
                    budget_left[cur]--;
                    if (budget_left[cur] < 0) begin
                        status[cur] = ST_FREE;
                        tid = cur; sw = 1;
                        ev = none_left() ? EV_ALLDONE : EV_EJECT;
                        pick_next();
                    end else if (high_q.size() > 0 && is_high[cur]) begin
                        if (budget_left[high_q[0]] < budget_left[cur]) begin
                            s = cur;
                            status[s] = ST_READY;
                            sorted_insert(s);
                            pick_next();
                            ev = EV_PREEMPT; tid = s; sw = 1;
                        end
                    end else if (high_q.size() > 0) begin
                        s = cur;
                        requeue_low(s);
                        pick_next();
                        ev = EV_PREEMPT; tid = s; sw = 1;
                    end else if (!is_high[cur] && slice_left[cur] == 0) begin
                        s = cur;
                        requeue_low(s);
                        pick_next();
                        if (idle || cur != s) begin
                            ev = EV_QSWITCH; tid = s; sw = 1;
                        end
                    end
                end
            end
            ACT_CREATE: begin
                for (s = 0; s < NSlots; s++) if (status[s] == ST_FREE) break;
                if (s == NSlots) begin
                    ev = EV_CFAIL;
                end else begin
                    status[s] = ST_READY;
                    is_high[s] = r.prio_high;
                    slice_left[s] = slice_len();
                    budget_left[s] = r.budget;
                    ev = EV_CREATED; tid = s;
                    if (!r.prio_high) low_q.push_back(s);
                    else if (idle) sorted_insert(s);
                    else if (!is_high[cur]) begin
                        requeue_low(cur);
                        run_slot(s);
                        sw = 1;
                    end else if (int'(r.budget) < budget_left[cur]) begin
                        status[cur] = ST_READY;
                        sorted_insert(cur);
                        run_slot(s);
                        sw = 1;
                    end else sorted_insert(s);
                end
            end
            ACT_READ: begin
                if (!idle && r.cache_miss) begin
                    s = cur;
                    status[s] = ST_BLOCK;
                    if (!is_high[s]) slice_left[s] = slice_len();
                    blk_q.push_back(s);
                    pick_next();
                    ev = EV_BLOCK; tid = s; sw = 1;
                end
            end
            ACT_DONE: begin
                if (blk_q.size() > 0) begin
                    s = blk_q.pop_front();
                    status[s] = ST_READY;
                    if (is_high[s]) sorted_insert(s);
                    else low_q.push_back(s);
                    ev = EV_WOKEN; tid = s;
                end
            end
            ACT_EXIT: begin
                if (!idle) begin
                    status[cur] = ST_FREE;
                    tid = cur; sw = 1;
                    ev = none_left() ? EV_ALLDONE : EV_FINISH;
                    pick_next();
                end
            end
            default: ;
        endcase
        o.event_res = ev;
        o.thread_id = tid[3:0];
        o.running_id = idle ? 4'd0 : cur[3:0];
        o.idle = idle;
        o.switched = sw;
        return o;
    endfunction

    // valid stays up after a request is taken until the next request or a pause
    task automatic send_request(input logic [2:0] act, input logic hi,
                                input logic [15:0] bud, input logic miss);
        t_req r;
        r.action = act;
        r.prio_high = hi;
        r.budget = bud;
        r.cache_miss = miss;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {3'd0, r};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sched_expected.push_back(schedule(r));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sched_expected.size() > 0) @(posedge i_clk);
        // a request with no result pending can still be in work
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [7:0] q);
        drain();
        i_cfg_data <= q;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        quantum = q;
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[13:0];
                if (sched_expected.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected result %h", got);
                end else begin
                    want = sched_expected.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: ev %0d/%0d tid %0d/%0d run %0d/%0d idle %b/%b sw %b/%b",
                                     want.event_res, got.event_res, want.thread_id, got.thread_id,
                                     want.running_id, got.running_id, want.idle, got.idle,
                                     want.switched, got.switched);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WatchLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // random event mix, biased toward ticks and creates so threads actually run
    task automatic random_request();
        int k;
        logic [15:0] bud;
        k = $urandom_range(99);
        case ($urandom_range(3))
            0: bud = 16'($urandom_range(15));
            1: bud = 16'($urandom_range(60));
            2: bud = 16'($urandom);
            default: bud = 16'($urandom_range(200));
        endcase
        if (k < 50) send_request(ACT_TICK, 1'($urandom), 16'($urandom), 1'($urandom));
        else if (k < 68) send_request(ACT_CREATE, 1'($urandom), bud, 1'($urandom));
        else if (k < 78)
            send_request(ACT_READ, 1'($urandom), 16'($urandom), $urandom_range(3) != 0);
        else if (k < 88) send_request(ACT_DONE, 1'($urandom), 16'($urandom), 1'($urandom));
        else if (k < 96) send_request(ACT_EXIT, 1'($urandom), 16'($urandom), 1'($urandom));
        else send_request(3'($urandom_range(7)), 1'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic test_directed();
        int i;
        send_request(ACT_TICK, 0, 0, 0);            // idle with nothing to run
        send_request(ACT_READ, 0, 0, 1);            // read while idle
        send_request(ACT_EXIT, 0, 0, 0);            // exit while idle
        send_request(ACT_DONE, 0, 0, 0);            // nothing blocked
        send_request(ACT_CREATE, 1, 16'd5, 0);      // high while idle: queued
        send_request(ACT_TICK, 0, 0, 0);            // leave idle
        send_request(ACT_CREATE, 1, 16'd2, 0);      // shorter high preempts
        send_request(ACT_CREATE, 1, 16'd5, 0);      // tie goes behind
        send_request(ACT_CREATE, 0, 16'hFFFF, 0);
        send_request(ACT_READ, 0, 0, 0);            // cache hit
        send_request(ACT_READ, 0, 0, 1);            // block
        send_request(ACT_DONE, 0, 0, 0);            // wake
        for (i = 0; i < 12; i++) send_request(ACT_CREATE, i[0], 16'($urandom_range(3)), 1);
        send_request(3'd7, 1, 16'hFFFF, 1);         // unused action code
        for (i = 0; i < 8; i++) send_request(ACT_TICK, 0, 0, 0);
    endtask

    task automatic test_quantum_extremes();
        int i;
        write_quantum(8'd1);
        send_request(ACT_CREATE, 0, 16'd3, 0);
        send_request(ACT_CREATE, 0, 16'd0, 0);
        for (i = 0; i < 10; i++) send_request(ACT_TICK, 0, 0, 0);
        write_quantum(8'd0);
        for (i = 0; i < 10; i++) send_request(ACT_TICK, 0, 0, 0);
        write_quantum(8'd255);
        for (i = 0; i < 10; i++) send_request(ACT_EXIT, 0, 0, 0);
    endtask

    task automatic test_random(input int n, input int sidle, input int ridle);
        int i;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (i = 0; i < n; i++) begin
            random_request();
            if (i == n / 2) drain();                // let everything settle once
        end
        drain();
        write_quantum(8'($urandom_range(1, 12)));
    endtask

    initial begin
        int k;
        errors = 0;
        mismatches = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        quantum = 8'd10;
        for (k = 0; k < NSlots; k++) begin
            status[k] = ST_FREE;
            is_high[k] = 0;
            slice_left[k] = 0;
            budget_left[k] = 0;
        end
        cur = 0;
        idle = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_quantum_extremes();
        test_random(500, 26, 65);
        test_random(500, 65, 26);
        test_random(500, 0, 0);
        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
